/* design/ltd_pkg.sv */
package ltd_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned FracW  = 16;
  localparam int unsigned NodeW  = 9;
  localparam int unsigned DivW   = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned InDataW  = 208;
  localparam int unsigned OutDataW = 96;

  localparam logic [CfgIdxW-1:0] RegDivisions = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMinX      = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMinY      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMinZ      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMaxX      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMaxY      = 3'd5;
  localparam logic [CfgIdxW-1:0] RegMaxZ      = 3'd6;

  typedef enum logic {
    KindLoad  = 1'b0,
    KindQuery = 1'b1
  } kind_e;

  // one classified item handed from front to back
  typedef struct packed {
    kind_e                     kind;
    logic [NodeW-1:0]          node_index;
    logic signed [CoordW-1:0]  px;
    logic signed [CoordW-1:0]  py;
    logic signed [CoordW-1:0]  pz;
    logic signed [CoordW-1:0]  sx;
    logic signed [CoordW-1:0]  sy;
    logic signed [CoordW-1:0]  sz;
  } item_t;

  typedef enum logic [2:0] {
    BkIdle,
    BkDiv,
    BkIndex,
    BkRead,
    BkLerp,
    BkOut
  } bk_state_e;

  function automatic logic signed [CoordW-1:0] sat32(input logic signed [CoordW+1:0] v);
    logic signed [CoordW+1:0] mx;
    logic signed [CoordW+1:0] mn;
    mx = (CoordW+2)'(signed'({1'b0, {(CoordW-1){1'b1}}}));
    mn = -mx - (CoordW+2)'(1);
    if (v > mx) return {1'b0, {(CoordW-1){1'b1}}};
    else if (v < mn) return {1'b1, {(CoordW-1){1'b0}}};
    else return v[CoordW-1:0];
  endfunction

endpackage

/* design/ltd_front.sv */
module ltd_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [ltd_pkg::InDataW-1:0] in_data_i,
  input  logic                     in_user_i,
  output logic                     q_valid_o,
  input  logic                     q_ready_i,
  output ltd_pkg::item_t           q_item_o
);
  import ltd_pkg::*;

  // two-entry queue between front and back
  item_t    mem_q [2];
  logic     wp_q, rp_q;
  logic [1:0] cnt_q;
  item_t    it;
  logic signed [CoordW:0] ex, ey, ez;
  logic push, pop;

  always_comb begin
    it.kind       = kind_e'(in_user_i);
    it.node_index = in_data_i[NodeW-1:0];
    it.px = in_data_i[NodeW +: CoordW];
    it.py = in_data_i[NodeW+CoordW +: CoordW];
    it.pz = in_data_i[NodeW+2*CoordW +: CoordW];
    ex = $signed({in_data_i[NodeW+4*CoordW-1], in_data_i[NodeW+3*CoordW +: CoordW]})
       - $signed({it.px[CoordW-1], it.px});
    ey = $signed({in_data_i[NodeW+5*CoordW-1], in_data_i[NodeW+4*CoordW +: CoordW]})
       - $signed({it.py[CoordW-1], it.py});
    ez = $signed({in_data_i[NodeW+6*CoordW-1], in_data_i[NodeW+5*CoordW +: CoordW]})
       - $signed({it.pz[CoordW-1], it.pz});
    it.sx = sat32({ex[CoordW], ex});
    it.sy = sat32({ey[CoordW], ey});
    it.sz = sat32({ez[CoordW], ez});
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop = q_valid_o && q_ready_i;
  assign q_item_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= it;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

/* design/ltd_div.sv */
module ltd_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [32:0]        num_i,
  input  logic signed [32:0]        den_i,
  output logic                      done_o,
  output logic [16:0]               u_o
);
  import ltd_pkg::*;

  // restoring divider, one quotient bit per cycle, 16 fraction bits
  logic [32:0] rem_q, rem_d, den_q, den_d;
  logic [15:0] quo_q, quo_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, spec_q, spec_d;
  logic [16:0] res_q, res_d;
  logic [33:0] sh;
  logic signed [32:0] n, dd;

  assign done_o = busy_q && (cnt_q == 5'd0);
  assign u_o = spec_q ? res_q : {1'b0, quo_q};

  always_comb begin
    rem_d = rem_q; den_d = den_q; quo_d = quo_q; cnt_d = cnt_q;
    busy_d = busy_q; spec_d = spec_q; res_d = res_q;
    n = num_i; dd = den_i;
    sh = {rem_q, 1'b0};
    if (start_i) begin
      if (dd < 0) begin n = -n; dd = -dd; end
      busy_d = 1'b1;
      rem_d = n[32:0];
      den_d = dd[32:0];
      quo_d = '0;
      spec_d = 1'b1;
      res_d = '0;
      cnt_d = 5'd0;
      if (den_i == 0 || n <= 0) res_d = '0;
      else if (n >= dd) res_d = 17'h10000;
      else begin spec_d = 1'b0; cnt_d = 5'd16; end
    end else if (busy_q && cnt_q != 5'd0) begin
      if (sh >= {1'b0, den_q}) begin
        rem_d = 33'(sh - {1'b0, den_q});
        quo_d = {quo_q[14:0], 1'b1};
      end else begin
        rem_d = sh[32:0];
        quo_d = {quo_q[14:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
    end else if (done_o) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; den_q <= den_d; quo_q <= quo_d; res_q <= res_d; spec_q <= spec_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= 5'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end
endmodule

/* design/ltd_back.sv */
module ltd_back #(
  parameter int unsigned MaxDivisions = 7
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  output logic                      q_ready_o,
  input  ltd_pkg::item_t            q_item_i,
  input  logic [ltd_pkg::DivW-1:0]  divisions_i,
  input  logic signed [31:0]        box_min_i [3],
  input  logic signed [31:0]        box_max_i [3],
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ltd_pkg::OutDataW-1:0] out_data_o
);
  import ltd_pkg::*;

  localparam int unsigned NodeDepth = 1 << NodeW;

  bk_state_e state_q, state_d;
  item_t     item_q;
  logic [1:0] ax_q, ax_d;
  logic [3:0] c_q;
  logic       rd_v_q;
  logic [DivW:0] lo_q [3], hi_q [3];
  logic [15:0] fr_q [3];
  logic signed [31:0] cx_q [8], cy_q [8], cz_q [8];
  logic [2:0] lv_q;
  logic [NodeW-1:0] idx;
  logic [DivW:0] d, i0, j0, k0;
  logic signed [31:0] rx_q, ry_q, rz_q;
  logic [OutDataW-1:0] out_q;
  logic ov_q;
  logic div_start, div_done, div_run_q;
  logic [16:0] div_u;
  logic signed [32:0] dnum, dden;
  logic [DivW+17:0] scaled;

  logic signed [31:0] mem_x [NodeDepth];
  logic signed [31:0] mem_y [NodeDepth];
  logic signed [31:0] mem_z [NodeDepth];

  assign d = ({1'b0, divisions_i} > (DivW+1)'(MaxDivisions)) ? (DivW+1)'(MaxDivisions)
                                                             : {1'b0, divisions_i};

  always_comb begin
    dnum = $signed({q_item_i.px[31], q_item_i.px});
    dden = '0;
    case (ax_q)
      2'd0: begin
        dnum = $signed({item_q.px[31], item_q.px}) - $signed({box_min_i[0][31], box_min_i[0]});
        dden = $signed({box_max_i[0][31], box_max_i[0]}) - $signed({box_min_i[0][31], box_min_i[0]});
      end
      2'd1: begin
        dnum = $signed({item_q.py[31], item_q.py}) - $signed({box_min_i[1][31], box_min_i[1]});
        dden = $signed({box_max_i[1][31], box_max_i[1]}) - $signed({box_min_i[1][31], box_min_i[1]});
      end
      default: begin
        dnum = $signed({item_q.pz[31], item_q.pz}) - $signed({box_min_i[2][31], box_min_i[2]});
        dden = $signed({box_max_i[2][31], box_max_i[2]}) - $signed({box_min_i[2][31], box_min_i[2]});
      end
    endcase
  end

  ltd_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(dnum), .den_i(dden),
    .done_o(div_done), .u_o(div_u)
  );

  // corner c: bit2 picks x, bit1 y, bit0 z
  always_comb begin
    i0 = c_q[2] ? hi_q[0] : lo_q[0];
    j0 = c_q[1] ? hi_q[1] : lo_q[1];
    k0 = c_q[0] ? hi_q[2] : lo_q[2];
    idx = NodeW'(i0 * (d + 1) * (d + 1) + j0 * (d + 1) + k0);
  end

  function automatic logic signed [31:0] lerp(input logic signed [31:0] a,
                                              input logic signed [31:0] b,
                                              input logic [15:0] t);
    logic signed [50:0] s;
    s = a * $signed({1'b0, 17'h10000 - 17'(t)}) + b * $signed({1'b0, t}) + 51'sd32768;
    return s[47:16];
  endfunction

  logic signed [31:0] zx [4], zy [4], zz [4], yx [2], yy [2], yz [2];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      zx[k] = lerp(cx_q[2*k], cx_q[2*k+1], fr_q[2]);
      zy[k] = lerp(cy_q[2*k], cy_q[2*k+1], fr_q[2]);
      zz[k] = lerp(cz_q[2*k], cz_q[2*k+1], fr_q[2]);
    end
  end

  logic signed [31:0] zx_q [4], zy_q [4], zz_q [4], yx_q [2], yy_q [2], yz_q [2];
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      yx[k] = lerp(zx_q[2*k], zx_q[2*k+1], fr_q[1]);
      yy[k] = lerp(zy_q[2*k], zy_q[2*k+1], fr_q[1]);
      yz[k] = lerp(zz_q[2*k], zz_q[2*k+1], fr_q[1]);
    end
  end

  assign q_ready_o = (state_q == BkIdle);
  assign out_valid_o = ov_q;
  assign out_data_o = out_q;
  // start one division per axis, then wait for its done
  assign div_start = (state_q == BkDiv) && !div_run_q;

  always_comb begin
    state_d = state_q;
    ax_d = ax_q;
    scaled = (DivW+18)'(div_u) * (DivW+18)'(d);
    case (state_q)
      BkIdle: if (q_valid_i && q_item_i.kind == KindQuery) begin
        state_d = BkDiv; ax_d = 2'd0;
      end
      BkDiv: if (div_done) begin
        if (ax_q == 2'd2) state_d = BkRead;
        ax_d = ax_q + 2'd1;
      end
      BkRead: if (c_q == 4'd8 && !rd_v_q) state_d = BkLerp;
      BkLerp: if (lv_q == 3'b100) state_d = BkOut;
      BkOut: if (!ov_q || out_ready_i) state_d = BkIdle;
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_valid_i && q_ready_o) begin
      item_q <= q_item_i;
      if (q_item_i.kind == KindLoad) begin
        mem_x[q_item_i.node_index] <= q_item_i.sx;
        mem_y[q_item_i.node_index] <= q_item_i.sy;
        mem_z[q_item_i.node_index] <= q_item_i.sz;
      end
    end
    if (state_q == BkDiv && div_done) begin
      fr_q[ax_q] <= scaled[15:0];
      lo_q[ax_q] <= scaled[DivW+16:16];
      hi_q[ax_q] <= (scaled[DivW+16:16] < d) ? scaled[DivW+16:16] + 1'b1
                                             : scaled[DivW+16:16];
    end
    if (state_q == BkRead && c_q != 4'd8) begin
      cx_q[c_q[2:0]] <= mem_x[idx];
      cy_q[c_q[2:0]] <= mem_y[idx];
      cz_q[c_q[2:0]] <= mem_z[idx];
    end
    zx_q <= zx; zy_q <= zy; zz_q <= zz;
    yx_q <= yx; yy_q <= yy; yz_q <= yz;
    if (lv_q == 3'b010) begin
      rx_q <= lerp(yx_q[0], yx_q[1], fr_q[0]);
      ry_q <= lerp(yy_q[0], yy_q[1], fr_q[0]);
      rz_q <= lerp(yz_q[0], yz_q[1], fr_q[0]);
    end
    if (state_q == BkOut && (!ov_q || out_ready_i)) begin
      out_q <= {sat32(34'(item_q.pz) + 34'(rz_q)),
                sat32(34'(item_q.py) + 34'(ry_q)),
                sat32(34'(item_q.px) + 34'(rx_q))};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      ax_q <= 2'd0;
      c_q <= 4'd0;
      rd_v_q <= 1'b0;
      lv_q <= 3'd0;
      ov_q <= 1'b0;
      div_run_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ax_q <= ax_d;
      rd_v_q <= 1'b0;
      if (div_start) div_run_q <= 1'b1;
      else if (div_done) div_run_q <= 1'b0;
      if (state_q == BkRead) begin
        if (c_q != 4'd8) c_q <= c_q + 4'd1;
      end else c_q <= 4'd0;
      if (state_q == BkLerp) lv_q <= (lv_q == 3'd0) ? 3'b001 : {lv_q[1:0], 1'b0};
      else lv_q <= 3'd0;
      if (state_q == BkOut && (!ov_q || out_ready_i)) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end
endmodule

/* design/lattice_trilinear_displacement_core.sv */
// Trilinear lattice displacement core, Q16.16.
// Input stream s_axis: tuser is the kind (0 load a node, 1 query a point);
// tdata carries node_index, px, py, pz, dx, dy, dz from the lowest bit.
// A load stores (d - p) saturated as that node's displacement and returns
// nothing. A query returns one transaction on m_axis: out_x, out_y, out_z.
// The front stage computes load differences and holds items in a two-entry
// queue so the input keeps moving while the back stage works.
// A load is written to node memory when the back stage takes it. A query
// holds the back stage through three serial divisions (start, one quotient
// step per fraction bit, done; an axis at or outside the box edge or of zero
// extent skips the quotient steps), the eight corner reads, the z, y and x
// lerp registers and the output register. Queries run one at a time.
// The output register holds a result until m_axis_tready; the back stage
// stalls behind it and the queue fills, then s_axis_tready drops.
// Reset clears control state and config registers (divisions 1, box 0..1);
// node memory content is undefined until loaded. Issue config writes (cfg_we_i,
// cfg_idx_i, cfg_wdata_i) only while no transaction is in flight; index above 6
// is dropped.
module lattice_trilinear_displacement_core #(
  parameter int unsigned MaxDivisions = 7
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [207:0] s_axis_tdata,   // node_index, px, py, pz, dx, dy, dz
  input  logic         s_axis_tuser,   // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,   // out_x, out_y, out_z
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i
);
  import ltd_pkg::*;

  logic [DivW-1:0] div_q;
  logic signed [31:0] min_q [3], max_q [3];
  logic q_valid, q_ready;
  item_t q_item;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= DivW'(1);
      for (int a = 0; a < 3; a++) begin
        min_q[a] <= '0;
        max_q[a] <= 32'sh0001_0000;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegDivisions: div_q <= cfg_wdata_i[DivW-1:0];
        RegMinX: min_q[0] <= cfg_wdata_i;
        RegMinY: min_q[1] <= cfg_wdata_i;
        RegMinZ: min_q[2] <= cfg_wdata_i;
        RegMaxX: max_q[0] <= cfg_wdata_i;
        RegMaxY: max_q[1] <= cfg_wdata_i;
        RegMaxZ: max_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ltd_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_data_i(s_axis_tdata), .in_user_i(s_axis_tuser),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  ltd_back #(.MaxDivisions(MaxDivisions)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .divisions_i(div_q), .box_min_i(min_q), .box_max_i(max_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(m_axis_tdata)
  );
endmodule

/* design/ltd_checker.sv */
module ltd_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [95:0]  m_axis_tdata
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");
  a_rst_idle: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result during reset");
  a_rst_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> s_axis_tready)
    else $error("not ready after reset");
endmodule

bind lattice_trilinear_displacement_core ltd_checker u_ltd_checker (
  .clk_i, .rst_ni, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
